// File: src/lav_pkg.sv
// lav_pkg: shared types, widths and constants of the look-at view matrix unit
// no dependencies; used by every file under src

package lav_pkg;

  // fixed point format of every input and output word
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // pre-scaling puts the largest magnitude in [2^(SCL_BITS-1), 2^SCL_BITS)
  localparam int SCL_BITS  = 30;
  localparam int SUM_W     = 2 * SCL_BITS + 2;          // sum of three squares
  localparam int ROOT_BITS = SCL_BITS + 1;              // floor(sqrt) of the sum
  localparam int Q_BITS    = FRAC_BITS + 2;             // quotient bits of a unit component
  localparam int DIV_W     = SCL_BITS + FRAC_BITS + 2;  // dividend and partial remainder
  localparam int NRM_W     = Q_BITS + 1;                // signed unit component
  localparam int UP_W      = SCL_BITS + 1;              // signed scaled up hint
  localparam int CR_W      = UP_W + NRM_W + 1;          // signed cross product term
  localparam int ACC_W     = 2 * WORD_BITS + 4;         // rounding and saturation width

  // pipeline depths
  localparam int SCALE_LAT = 3;
  localparam int NORM_LAT  = SCALE_LAT + 4 + ROOT_BITS + Q_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // row codes
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;
  localparam logic [1:0] ROW_W = 2'd3;

  localparam word_t ONE_WORD = WORD_BITS'(1) << FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ACC_WMAX =
    {{(ACC_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_WMIN =
    {{(ACC_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t fwd_x;
    word_t fwd_y;
    word_t fwd_z;
    word_t up_x;
    word_t up_y;
    word_t up_z;
  } lav_in_t;

  typedef struct packed {
    logic [1:0] row_index;
    word_t      col_0;
    word_t      col_1;
    word_t      col_2;
    word_t      col_3;
    logic       degenerate;
    logic       last_row;
  } lav_out_t;

  // clamp to the signed word range
  function automatic word_t sat_word(input logic signed [ACC_W-1:0] v);
    word_t r;
    if (v > ACC_WMAX) begin
      r = ACC_WMAX[WORD_BITS-1:0];
    end else if (v < ACC_WMIN) begin
      r = ACC_WMIN[WORD_BITS-1:0];
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/lav_scale.sv
// lav_scale: three-stage power-of-two pre-scaling of a signed 3-vector
// depends on lav_pkg

module lav_scale #(
  parameter int VEC_W = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [VEC_W-1:0]    vec [3],
  output logic [lav_pkg::SCL_BITS-1:0] mag [3],
  output logic [2:0]                 neg
);
  import lav_pkg::*;

  localparam int IDX_W = $clog2(VEC_W);
  localparam int EXT_W = VEC_W + SCL_BITS;

  logic [VEC_W-1:0]    a_nxt [3];
  logic [VEC_W-1:0]    a1_r  [3];
  logic [VEC_W-1:0]    a2_r  [3];
  logic [2:0]          n1_r, n2_r, n3_r;
  logic [VEC_W-1:0]    or_v;
  logic [IDX_W-1:0]    msb_nxt, msb_r;
  logic [SCL_BITS-1:0] m_nxt [3];
  logic [SCL_BITS-1:0] m_r   [3];

  // magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_nxt[i] = vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
    end
  end

  // top set bit of the largest magnitude equals that of the or of all three
  always_comb begin
    or_v    = a1_r[0] | a1_r[1] | a1_r[2];
    msb_nxt = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (or_v[i]) begin
        msb_nxt = IDX_W'(i);
      end
    end
  end

  // right shift truncates, left shift is exact, zero stays zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb_r >= IDX_W'(SCL_BITS - 1)) begin
        m_nxt[i] = SCL_BITS'(a2_r[i] >> (msb_r - IDX_W'(SCL_BITS - 1)));
      end else begin
        m_nxt[i] = SCL_BITS'(EXT_W'(a2_r[i]) << (IDX_W'(SCL_BITS - 1) - msb_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= a_nxt;
      n1_r  <= {vec[2][VEC_W-1], vec[1][VEC_W-1], vec[0][VEC_W-1]};
      a2_r  <= a1_r;
      n2_r  <= n1_r;
      msb_r <= msb_nxt;
      m_r   <= m_nxt;
      n3_r  <= n2_r;
    end
  end

  assign mag = m_r;
  assign neg = n3_r;

endmodule

// File: src/lav_norm.sv
// lav_norm: pipelined normalization of a signed 3-vector to unit length
// depends on lav_pkg and lav_scale; bit-per-stage square root and division

module lav_norm #(
  parameter int VEC_W = 32
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [VEC_W-1:0]          vec  [3],
  output logic signed [lav_pkg::NRM_W-1:0] norm [3],
  output logic                             zero
);
  import lav_pkg::*;

  logic [SCL_BITS-1:0]   mg [3];
  logic [2:0]            ng;

  // squares
  logic [2*SCL_BITS-1:0] sq_r [3];
  logic [SCL_BITS-1:0]   sq_mag_r [3];
  logic [2:0]            sq_neg_r;

  // square root stages, index 0 holds the sum
  logic [SUM_W-1:0]      rt_rem_r  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]  rt_root_r [ROOT_BITS+1];
  logic [SCL_BITS-1:0]   rt_mag_r  [ROOT_BITS+1][3];
  logic [2:0]            rt_neg_r  [ROOT_BITS+1];
  logic                  rt_zero_r [ROOT_BITS+1];

  // division stages, index 0 holds the rounded dividends
  logic [DIV_W-1:0]      dv_rem_r  [Q_BITS+1][3];
  logic [Q_BITS-1:0]     dv_q_r    [Q_BITS+1][3];
  logic [ROOT_BITS-1:0]  dv_len_r  [Q_BITS+1];
  logic [2:0]            dv_neg_r  [Q_BITS+1];
  logic                  dv_zero_r [Q_BITS+1];

  logic signed [NRM_W-1:0] nrm_r [3];
  logic                    zero_r;

  lav_scale #(.VEC_W(VEC_W)) u_scale (
    .clk (clk),
    .en  (en),
    .vec (vec),
    .mag (mg),
    .neg (ng)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mg[i] * mg[i];
      end
      sq_mag_r <= mg;
      sq_neg_r <= ng;

      rt_rem_r[0]  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      rt_root_r[0] <= '0;
      rt_mag_r[0]  <= sq_mag_r;
      rt_neg_r[0]  <= sq_neg_r;
      rt_zero_r[0] <= (sq_r[0] == '0) && (sq_r[1] == '0) && (sq_r[2] == '0);
    end
  end

  // one root bit per stage, remainder kept as sum minus root squared
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    localparam int B = ROOT_BITS - 1 - k;
    logic [SUM_W:0] trial;
    logic           fits;

    assign trial = ((SUM_W+1)'(rt_root_r[k]) << (B + 1)) + ((SUM_W+1)'(1) << (2 * B));
    assign fits  = {1'b0, rt_rem_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt_rem_r[k+1]  <= fits ? SUM_W'({1'b0, rt_rem_r[k]} - trial) : rt_rem_r[k];
        rt_root_r[k+1] <= rt_root_r[k] | (fits ? (ROOT_BITS'(1) << B) : '0);
        rt_mag_r[k+1]  <= rt_mag_r[k];
        rt_neg_r[k+1]  <= rt_neg_r[k];
        rt_zero_r[k+1] <= rt_zero_r[k];
      end
    end
  end

  // dividend is the scaled magnitude in fixed point plus half the length
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= (DIV_W'(rt_mag_r[ROOT_BITS][i]) << FRAC_BITS)
                        + DIV_W'(rt_root_r[ROOT_BITS] >> 1);
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0]  <= rt_root_r[ROOT_BITS];
      dv_neg_r[0]  <= rt_neg_r[ROOT_BITS];
      dv_zero_r[0] <= rt_zero_r[ROOT_BITS];
    end
  end

  // restoring division, one quotient bit per stage on all three lanes
  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    localparam int B = Q_BITS - 1 - k;
    logic [DIV_W-1:0] dsor;
    logic [2:0]       fits;

    assign dsor = DIV_W'(dv_len_r[k]) << B;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        fits[i] = dv_rem_r[k][i] >= dsor;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k+1][i] <= fits[i] ? dv_rem_r[k][i] - dsor : dv_rem_r[k][i];
          dv_q_r[k+1][i]   <= dv_q_r[k][i] | (fits[i] ? (Q_BITS'(1) << B) : '0);
        end
        dv_len_r[k+1]  <= dv_len_r[k];
        dv_neg_r[k+1]  <= dv_neg_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
      end
    end
  end

  // sign back on, zero vector gives zero axis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero_r[Q_BITS]) begin
          nrm_r[i] <= '0;
        end else if (dv_neg_r[Q_BITS][i]) begin
          nrm_r[i] <= NRM_W'(0) - NRM_W'(dv_q_r[Q_BITS][i]);
        end else begin
          nrm_r[i] <= NRM_W'(dv_q_r[Q_BITS][i]);
        end
      end
      zero_r <= dv_zero_r[Q_BITS];
    end
  end

  assign norm = nrm_r;
  assign zero = zero_r;

endmodule

// File: src/look_at_view_matrix_unit.sv
// look_at_view_matrix_unit: right-handed look-at view matrix in signed fixed point
// depends on lav_pkg, lav_norm and lav_scale
//
// usage
//   in channel: one word holds camera position, viewing direction and up hint,
//   each three signed Q16.16 values; taken when in_valid and in_ready are high
//   out channel: four words per input, rows 0 to 3 in order, last_row on row 3;
//   rows 0..2 carry the x, y and z axes with the saturated translation term in
//   col_3, row 3 carries 0, 0, 0, 1.0; degenerate is the same on all four rows
//   path: an input that is taken passes two normalizers of 56 stages each plus
//   cross, dot and round stages before its first row shows on out_valid
//   throughput: the four-row output stage takes a new input when empty or as row 3 goes out;
//   the pipeline itself takes a word every cycle unless it holds (see stall)
//   stall: when out_ready is low the output stage holds its row, and once the
//   last pipeline stage is full every stage holds; in_ready drops then, nothing
//   is dropped or repeated
//   reset: rst_n clears the stage valid bits and the output stage, data
//   registers are not cleared

module look_at_view_matrix_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lav_pkg::lav_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lav_pkg::lav_out_t out_data
);
  import lav_pkg::*;

  // stage map: fwd normalizer, cross product (2), cross normalizer,
  // y axis (2), translation (3)
  localparam int NL       = NORM_LAT;
  localparam int TOTAL    = 2 * NL + 7;
  localparam int UD_LEN   = NL - SCALE_LAT;
  localparam int ZD_LEN   = NL + 2;
  localparam int PD_LEN   = 2 * NL + 4;
  localparam int PR_W     = UP_W + NRM_W;
  localparam int YP_W     = 2 * NRM_W;
  localparam int TS_W     = 2 * WORD_BITS + 2;

  logic                     adv;
  logic                     ser_take;
  logic                     out_fire;
  logic [TOTAL-1:0]         vld_r;

  word_t                    fwd_vec [3];
  word_t                    up_vec  [3];
  word_t                    pos_vec [3];

  // forward normalizer and up scaler
  logic signed [NRM_W-1:0]  nf [3];
  logic                     nf_zero;
  logic [SCL_BITS-1:0]      um [3];
  logic [2:0]               un;
  logic signed [UP_W-1:0]   ud_r [UD_LEN][3];
  word_t                    pd_r [PD_LEN][3];

  // cross product
  logic signed [NRM_W-1:0]  z_c  [3];
  logic signed [PR_W-1:0]   cp_r [6];
  logic signed [CR_W-1:0]   c_r  [3];
  logic signed [NRM_W-1:0]  zd_r [ZD_LEN][3];
  logic                     df_r [ZD_LEN];

  // cross normalizer
  logic signed [NRM_W-1:0]  nx [3];
  logic                     nx_zero;

  // y axis and rotation words
  logic signed [YP_W-1:0]   yp_r [6];
  logic signed [NRM_W-1:0]  z1_r [3];
  logic signed [NRM_W-1:0]  x1_r [3];
  logic                     deg1_r;
  logic signed [ACC_W-1:0]  yt   [3];
  word_t                    ax2_r [3][3];
  logic                     deg2_r;

  // translation
  logic signed [2*WORD_BITS-1:0] tp_r [3][3];
  word_t                    ax3_r [3][3];
  logic                     deg3_r;
  logic signed [TS_W-1:0]   ts_r [3];
  word_t                    ax4_r [3][3];
  logic                     deg4_r;
  logic signed [ACC_W-1:0]  tt   [3];
  word_t                    tr5_r [3];
  word_t                    ax5_r [3][3];
  logic                     deg5_r;

  // output stage
  word_t                    rot_r [3][3];
  word_t                    tr_r  [3];
  logic                     deg_r;
  logic [1:0]               row_r;
  logic                     ser_vld_r;

  assign fwd_vec[0] = in_data.fwd_x;
  assign fwd_vec[1] = in_data.fwd_y;
  assign fwd_vec[2] = in_data.fwd_z;
  assign up_vec[0]  = in_data.up_x;
  assign up_vec[1]  = in_data.up_y;
  assign up_vec[2]  = in_data.up_z;
  assign pos_vec[0] = in_data.pos_x;
  assign pos_vec[1] = in_data.pos_y;
  assign pos_vec[2] = in_data.pos_z;

  // whole pipeline moves together; it holds only when its last stage is full
  // and the output stage cannot take that word
  assign ser_take = !ser_vld_r || (out_ready && (row_r == ROW_W));
  assign adv      = !vld_r[TOTAL-1] || ser_take;
  assign in_ready = adv;
  assign out_fire = ser_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOTAL-2:0], in_valid};
    end
  end

  lav_norm #(.VEC_W(WORD_BITS)) u_norm_fwd (
    .clk  (clk),
    .en   (adv),
    .vec  (fwd_vec),
    .norm (nf),
    .zero (nf_zero)
  );

  lav_scale #(.VEC_W(WORD_BITS)) u_scale_up (
    .clk (clk),
    .en  (adv),
    .vec (up_vec),
    .mag (um),
    .neg (un)
  );

  // up hint and position ride alongside until they are needed
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ud_r[0][i] <= un[i] ? UP_W'(0) - UP_W'(um[i]) : UP_W'(um[i]);
      end
      for (int k = 1; k < UD_LEN; k++) begin
        ud_r[k] <= ud_r[k-1];
      end
      pd_r[0] <= pos_vec;
      for (int k = 1; k < PD_LEN; k++) begin
        pd_r[k] <= pd_r[k-1];
      end
    end
  end

  // z axis is the negated unit forward vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      z_c[i] = -nf[i];
    end
  end

  // cross of up hint and z, products then differences
  always_ff @(posedge clk) begin
    if (adv) begin
      cp_r[0] <= ud_r[UD_LEN-1][1] * z_c[2];
      cp_r[1] <= ud_r[UD_LEN-1][2] * z_c[1];
      cp_r[2] <= ud_r[UD_LEN-1][2] * z_c[0];
      cp_r[3] <= ud_r[UD_LEN-1][0] * z_c[2];
      cp_r[4] <= ud_r[UD_LEN-1][0] * z_c[1];
      cp_r[5] <= ud_r[UD_LEN-1][1] * z_c[0];
      zd_r[0] <= z_c;
      df_r[0] <= nf_zero;
      for (int k = 1; k < ZD_LEN; k++) begin
        zd_r[k] <= zd_r[k-1];
        df_r[k] <= df_r[k-1];
      end
      c_r[0] <= CR_W'(cp_r[0]) - CR_W'(cp_r[1]);
      c_r[1] <= CR_W'(cp_r[2]) - CR_W'(cp_r[3]);
      c_r[2] <= CR_W'(cp_r[4]) - CR_W'(cp_r[5]);
    end
  end

  lav_norm #(.VEC_W(CR_W)) u_norm_cross (
    .clk  (clk),
    .en   (adv),
    .vec  (c_r),
    .norm (nx),
    .zero (nx_zero)
  );

  // y axis = z cross x, rounded half up
  always_comb begin
    yt[0] = ACC_W'(yp_r[0]) - ACC_W'(yp_r[1]) + ACC_HALF;
    yt[1] = ACC_W'(yp_r[2]) - ACC_W'(yp_r[3]) + ACC_HALF;
    yt[2] = ACC_W'(yp_r[4]) - ACC_W'(yp_r[5]) + ACC_HALF;
  end

  // translation = round(-dot(axis, pos)), saturated
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tt[r] = ACC_HALF - ACC_W'(ts_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yp_r[0] <= zd_r[ZD_LEN-1][1] * nx[2];
      yp_r[1] <= zd_r[ZD_LEN-1][2] * nx[1];
      yp_r[2] <= zd_r[ZD_LEN-1][2] * nx[0];
      yp_r[3] <= zd_r[ZD_LEN-1][0] * nx[2];
      yp_r[4] <= zd_r[ZD_LEN-1][0] * nx[1];
      yp_r[5] <= zd_r[ZD_LEN-1][1] * nx[0];
      z1_r    <= zd_r[ZD_LEN-1];
      x1_r    <= nx;
      deg1_r  <= df_r[ZD_LEN-1] || nx_zero;

      for (int j = 0; j < 3; j++) begin
        ax2_r[0][j] <= sat_word(ACC_W'(x1_r[j]));
        ax2_r[1][j] <= sat_word(yt[j] >>> FRAC_BITS);
        ax2_r[2][j] <= sat_word(ACC_W'(z1_r[j]));
      end
      deg2_r <= deg1_r;

      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          tp_r[r][j] <= ax2_r[r][j] * pd_r[PD_LEN-1][j];
        end
      end
      ax3_r  <= ax2_r;
      deg3_r <= deg2_r;

      for (int r = 0; r < 3; r++) begin
        ts_r[r] <= TS_W'(tp_r[r][0]) + TS_W'(tp_r[r][1]) + TS_W'(tp_r[r][2]);
      end
      ax4_r  <= ax3_r;
      deg4_r <= deg3_r;

      for (int r = 0; r < 3; r++) begin
        tr5_r[r] <= sat_word(tt[r] >>> FRAC_BITS);
      end
      ax5_r  <= ax4_r;
      deg5_r <= deg4_r;
    end
  end

  // output stage: holds one matrix and hands out its four rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      row_r     <= ROW_X;
    end else if (ser_take) begin
      ser_vld_r <= vld_r[TOTAL-1];
      row_r     <= ROW_X;
    end else if (out_fire) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take && vld_r[TOTAL-1]) begin
      rot_r <= ax5_r;
      tr_r  <= tr5_r;
      deg_r <= deg5_r;
    end
  end

  assign out_valid = ser_vld_r;

  always_comb begin
    out_data.row_index  = row_r;
    out_data.degenerate = deg_r;
    out_data.last_row   = (row_r == ROW_W);
    case (row_r)
      ROW_X: begin
        out_data.col_0 = rot_r[0][0];
        out_data.col_1 = rot_r[0][1];
        out_data.col_2 = rot_r[0][2];
        out_data.col_3 = tr_r[0];
      end
      ROW_Y: begin
        out_data.col_0 = rot_r[1][0];
        out_data.col_1 = rot_r[1][1];
        out_data.col_2 = rot_r[1][2];
        out_data.col_3 = tr_r[1];
      end
      ROW_Z: begin
        out_data.col_0 = rot_r[2][0];
        out_data.col_1 = rot_r[2][1];
        out_data.col_2 = rot_r[2][2];
        out_data.col_3 = tr_r[2];
      end
      default: begin
        out_data.col_0 = '0;
        out_data.col_1 = '0;
        out_data.col_2 = '0;
        out_data.col_3 = ONE_WORD;
      end
    endcase
  end

endmodule

// File: src/lav_port_chk.sv
// lav_port_chk: port-level checks of look_at_view_matrix_unit, bound to the top
// depends on lav_pkg

module lav_port_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input lav_pkg::lav_out_t out_data
);
  import lav_pkg::*;

  logic [1:0] exp_row_r;
  logic       deg_seen_r;
  logic       out_fire;

  assign out_fire = out_valid && out_ready;

  // expected row of the next word and degenerate flag of the current run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r  <= ROW_X;
      deg_seen_r <= 1'b0;
    end else if (out_fire) begin
      exp_row_r <= out_data.last_row ? ROW_X : exp_row_r + 2'd1;
      if (out_data.row_index == ROW_X) begin
        deg_seen_r <= out_data.degenerate;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row_index == exp_row_r)
    else $error("rows out of order");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_row == (out_data.row_index == ROW_W))
    else $error("last_row flag on wrong row");

  a_row_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_index == ROW_W |->
      out_data.col_0 == '0 && out_data.col_1 == '0 &&
      out_data.col_2 == '0 && out_data.col_3 == ONE_WORD)
    else $error("bad homogeneous row");

  a_deg_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_index != ROW_X |-> out_data.degenerate == deg_seen_r)
    else $error("degenerate flag changed within a matrix");

endmodule

bind look_at_view_matrix_unit lav_port_chk u_lav_port_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
